// ===== rtl/bidirectional_bubble_sorter_core_assert.svh =====
// assertion macros for the bidirectional bubble sorter core
`ifndef BIDIRECTIONAL_BUBBLE_SORTER_CORE_ASSERT_SVH
`define BIDIRECTIONAL_BUBBLE_SORTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define BBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define BBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define BBS_ASSERT(lbl, clk, rstn, prop, msg)
`define BBS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/bbs_pkg.sv =====
// shared types, constants and codes of the bidirectional bubble sorter
package bbs_pkg;

  // store depth and derived widths
  localparam int unsigned ELEMENTS = 1024;
  localparam int unsigned POS_W    = $clog2(ELEMENTS);

  // field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = 19;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned OP_W    = 2;

  // stream word widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((IDX_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8;

  // configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_SORT_DESCENDING = 1'b0;
  localparam logic        REG_ELEMENT_COUNT   = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SORT  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_LOAD,
    SEQ_RUN,
    SEQ_FLUSH,
    SEQ_RESULT
  } seq_state_e;

  typedef struct packed {
    logic               sort_descending;
    logic [COUNT_W-1:0] element_count;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  comparison_count;
    logic [CNT_W-1:0]  swap_count;
  } result_t;

endpackage

// ===== rtl/bbs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
module bbs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bbs_cfg_regs.sv =====
// configuration registers behind the apb-style port
module bbs_cfg_regs import bbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic               desc_q, desc_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    desc_d  = desc_q;
    count_d = count_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SORT_DESCENDING: desc_d  = pwdata[0];
        REG_ELEMENT_COUNT:   count_d = pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q  <= 1'b0;
      count_q <= COUNT_RESET;
    end else begin
      desc_q  <= desc_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SORT_DESCENDING: prdata = APB_DATA_W'(desc_q);
      REG_ELEMENT_COUNT:   prdata = APB_DATA_W'(count_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.sort_descending = desc_q;
  assign cfg_o.element_count   = count_q;

endmodule

// ===== rtl/bbs_sequencer.sv =====
// item sequencer: element access and the shaker sort walk over the ram
`include "bidirectional_bubble_sorter_core_assert.svh"

module bbs_sequencer import bbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  item_t             in_item_i,
  output logic              in_ready_o,
  input  cfg_t              cfg_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output result_t           res_o,
  output logic              ram_we_o,
  output logic [POS_W-1:0]  ram_waddr_o,
  output logic [DATA_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [POS_W-1:0]  ram_raddr_o,
  input  logic [DATA_W-1:0] ram_rdata_i
);

  localparam int unsigned N_W   = POS_W + 1;
  localparam int unsigned CMP_W = (N_W > COUNT_W) ? N_W : COUNT_W;

  seq_state_e state_q, state_d;

  logic [POS_W-1:0]  lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic              back_q, back_d;
  logic [DATA_W-1:0] carry_q, carry_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic              in_store_q, in_store_d;
  logic [CNT_W-1:0]  cmp_q, cmp_d, swp_q, swp_d;

  logic              accept;
  logic [31:0]       idx_ext;
  logic [POS_W-1:0]  addr;
  logic              in_store;
  logic [CMP_W-1:0]  n_clamped;
  logic              n_short;

  logic signed [DATA_W-1:0] left_val, right_val;
  logic                     out_of_order;
  logic [DATA_W-1:0]        low_slot, high_slot;
  logic [POS_W-1:0]         pos_inc, pos_dec, pos_inc2, pos_dec2, hi_dec, lo_inc;
  logic                     fwd_turn, bwd_turn, fwd_done, bwd_done, run_done;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SEQ_IDLE);

  // index decode against the store depth
  assign idx_ext  = 32'(in_item_i.idx);
  assign addr     = idx_ext[POS_W-1:0];
  assign in_store = idx_ext < 32'(ELEMENTS);

  // sort length, clamped to the store
  always_comb begin
    if (CMP_W'(cfg_i.element_count) > CMP_W'(ELEMENTS)) begin
      n_clamped = CMP_W'(ELEMENTS);
    end else begin
      n_clamped = CMP_W'(cfg_i.element_count);
    end
  end
  assign n_short = n_clamped < CMP_W'(2);

  // compare-and-swap: the carried element sits at pos, the ram word beside it
  assign left_val     = back_q ? ram_rdata_i : carry_q;
  assign right_val    = back_q ? carry_q : ram_rdata_i;
  assign out_of_order = cfg_i.sort_descending ? (left_val < right_val)
                                              : (left_val > right_val);
  assign low_slot     = out_of_order ? right_val : left_val;
  assign high_slot    = out_of_order ? left_val : right_val;

  assign pos_inc  = pos_q + 1'b1;
  assign pos_dec  = pos_q - 1'b1;
  assign pos_inc2 = pos_q + POS_W'(2);
  assign pos_dec2 = pos_q - POS_W'(2);
  assign hi_dec   = hi_q - 1'b1;
  assign lo_inc   = lo_q + 1'b1;
  assign fwd_turn = (pos_inc == hi_q);
  assign bwd_turn = (pos_dec == lo_q);
  assign fwd_done = fwd_turn && (hi_dec == lo_q);
  assign bwd_done = bwd_turn && (lo_inc == hi_q);
  assign run_done = back_q ? bwd_done : fwd_done;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          unique case (in_item_i.op)
            OP_READ:  state_d = SEQ_READ;
            OP_SORT:  state_d = n_short ? SEQ_RESULT : SEQ_LOAD;
            OP_WRITE: state_d = SEQ_IDLE;
            default:  state_d = SEQ_IDLE;
          endcase
        end
      end
      SEQ_READ:  state_d = SEQ_RESULT;
      SEQ_LOAD:  state_d = SEQ_RUN;
      SEQ_RUN: begin
        if (run_done) begin
          state_d = SEQ_FLUSH;
        end
      end
      SEQ_FLUSH: state_d = SEQ_RESULT;
      SEQ_RESULT: begin
        if (res_ready_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default:   state_d = SEQ_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    lo_d        = lo_q;
    hi_d        = hi_q;
    pos_d       = pos_q;
    back_d      = back_q;
    carry_d     = carry_q;
    value_d     = value_q;
    in_store_d  = in_store_q;
    cmp_d       = cmp_q;
    swp_d       = swp_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q;
    ram_wdata_o = carry_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = pos_q;
    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          unique case (in_item_i.op)
            OP_WRITE: begin
              ram_we_o    = in_store;
              ram_waddr_o = addr;
              ram_wdata_o = in_item_i.value;
            end
            OP_READ: begin
              ram_re_o    = 1'b1;
              ram_raddr_o = addr;
              in_store_d  = in_store;
            end
            OP_SORT: begin
              cmp_d   = '0;
              swp_d   = '0;
              value_d = '0;
              lo_d    = '0;
              pos_d   = '0;
              back_d  = 1'b0;
              if (n_short) begin
                hi_d = '0;
              end else begin
                hi_d        = POS_W'(n_clamped - 1'b1);
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_READ: begin
        value_d = in_store_q ? ram_rdata_i : '0;
      end
      SEQ_LOAD: begin
        // first element becomes the carry, its neighbour is fetched
        carry_d     = ram_rdata_i;
        ram_re_o    = 1'b1;
        ram_raddr_o = POS_W'(1);
      end
      SEQ_RUN: begin
        cmp_d    = cmp_q + 1'b1;
        swp_d    = swp_q + CNT_W'(out_of_order);
        ram_we_o = 1'b1;
        if (!back_q) begin
          if (!fwd_turn) begin
            ram_waddr_o = pos_q;
            ram_wdata_o = low_slot;
            carry_d     = high_slot;
            pos_d       = pos_inc;
            ram_re_o    = 1'b1;
            ram_raddr_o = pos_inc2;
          end else begin
            // top end settled, carry turns round with the lower one
            ram_waddr_o = pos_inc;
            ram_wdata_o = high_slot;
            carry_d     = low_slot;
            back_d      = 1'b1;
            hi_d        = hi_dec;
            ram_re_o    = !fwd_done;
            ram_raddr_o = pos_dec;
          end
        end else begin
          if (!bwd_turn) begin
            ram_waddr_o = pos_q;
            ram_wdata_o = high_slot;
            carry_d     = low_slot;
            pos_d       = pos_dec;
            ram_re_o    = 1'b1;
            ram_raddr_o = pos_dec2;
          end else begin
            // bottom end settled, carry turns round with the higher one
            ram_waddr_o = pos_dec;
            ram_wdata_o = low_slot;
            carry_d     = high_slot;
            back_d      = 1'b0;
            lo_d        = lo_inc;
            ram_re_o    = !bwd_done;
            ram_raddr_o = pos_inc;
          end
        end
      end
      SEQ_FLUSH: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = carry_q;
      end
      SEQ_RESULT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      pos_q   <= '0;
      back_q  <= 1'b0;
      cmp_q   <= '0;
      swp_q   <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      pos_q   <= pos_d;
      back_q  <= back_d;
      cmp_q   <= cmp_d;
      swp_q   <= swp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q    <= carry_d;
    value_q    <= value_d;
    in_store_q <= in_store_d;
  end

  assign res_valid_o            = (state_q == SEQ_RESULT);
  assign res_o.read_value       = value_q;
  assign res_o.comparison_count = cmp_q;
  assign res_o.swap_count       = swp_q;

  `BBS_ASSERT(a_no_rw_collision, clk_i, rst_ni, (ram_we_o && ram_re_o) |-> (ram_waddr_o != ram_raddr_o), "read and write hit the same entry")
  `BBS_ASSERT(a_bounds_apart, clk_i, rst_ni, (state_q == SEQ_RUN) |-> (lo_q < hi_q), "sort running with bounds met")
  `BBS_ASSERT(a_pos_in_bounds, clk_i, rst_ni, (state_q == SEQ_RUN) |-> (pos_q >= lo_q && pos_q <= hi_q), "sweep position outside bounds")
  `BBS_ASSERT(a_one_cmp_per_step, clk_i, rst_ni, (state_q == SEQ_RUN) |=> (cmp_q == CNT_W'($past(cmp_q) + 1'b1)), "comparison count skipped a step")

endmodule

// ===== rtl/bidirectional_bubble_sorter_core.sv =====
// top level of the bidirectional bubble sorter: stream ports, config port and output register
//
// The core keeps ELEMENTS signed 32-bit words in one simple dual-port ram
// (one write, one registered read). A write word gives no result. A read word's
// value passes through the ram read, the result stage and the output register.
// A sort word runs a cocktail shaker sort over entries 0 .. n-1, n being
// element_count clamped to the store; it makes n*(n-1)/2 compare-and-swap
// steps, one per cycle, since each step is one ram read and one ram write
// while the moving element stays in a carry register. Entry 0 is loaded into
// the carry and its neighbour fetched before the run, and the carry is written
// back after it, before the result reaches the output register; n below two
// skips the sort and gives a result at once with zero counts. A new word is
// taken as soon as the previous result has moved into the output register,
// even while it waits there. The store is not cleared by reset, so there is
// no start-up pass: an entry must be written before it is read or sorted.
// Configuration must only be written while idle.
module bidirectional_bubble_sorter_core import bbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input words
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // index[9:0], value[41:10], zero pad
  input  logic [OP_W-1:0]        s_axis_tuser,   // operation[1:0]
  // result words
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_value[31:0], comparison_count[50:32],
                                                 // swap_count[69:51], zero pad
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  // ram port
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [POS_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // output register
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // unpack the input word
  assign item.op    = op_e'(s_axis_tuser);
  assign item.idx   = s_axis_tdata[IDX_W-1:0];
  assign item.value = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];

  bbs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbs_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_item_i   (item),
    .in_ready_o  (s_axis_tready),
    .cfg_i       (cfg),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // element store
  bbs_ram #(
    .DEPTH (ELEMENTS),
    .WIDTH (DATA_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // the result stage hands over when the output register is empty or draining
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = OUT_TDATA_W'({res.swap_count, res.comparison_count, res.read_value});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
